>>> sv/mbe_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and a helper function for the escape-time block.
package mbe_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 28;
	localparam int COUNT_BITS_DEF = 16;
	localparam int CELLS_DEF      = 4;
	localparam int WORD_BITS      = 32;
	localparam int STEP_BITS      = 31;
	localparam int LIMIT_BITS     = 16;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_REAL_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAG_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_REAL_STEP   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAG_STEP   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ITER_LIMIT  = 3'd4;

	localparam logic signed [WORD_BITS-1:0] RESET_REAL_ORIGIN = -32'sd536870912;
	localparam logic signed [WORD_BITS-1:0] RESET_IMAG_ORIGIN = -32'sd268435456;
	localparam logic [STEP_BITS-1:0]        RESET_STEP        = 31'd131072;
	localparam logic [LIMIT_BITS-1:0]       RESET_LIMIT       = 16'd1000;

	typedef logic signed [WORD_BITS-1:0] word_t;

	// Clamp a wide signed value into the 32-bit signed range.
	function automatic word_t sat_word(input logic signed [WORD_BITS+2:0] v);
		logic signed [WORD_BITS+2:0] hi;
		logic signed [WORD_BITS+2:0] lo;
		hi = 35'sd2147483647;
		lo = -35'sd2147483648;
		if (v > hi) begin
			return word_t'(hi[WORD_BITS-1:0]);
		end else if (v < lo) begin
			return word_t'(lo[WORD_BITS-1:0]);
		end
		return word_t'(v[WORD_BITS-1:0]);
	endfunction

endpackage

>>> sv/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// Top level: configuration registers, point mapping and a ring of iteration cells.
// One pixel is worked on at a time. After start, c is formed in the map_s1 and map_s2
// stages, then the point circulates through a ring of CELLS cells, each doing one
// iteration in a squaring stage and a test-and-update stage, until it escapes or
// reaches the limit (1000 by default). The next start can be taken once busy has fallen.
// The result is shown for one cycle with done high; the receiver cannot stall it, and
// busy stays high until that cycle has passed. Configuration is written through
// cfg_we, cfg_idx, cfg_data.
module mandelbrot_escape_time
	import mbe_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int CELLS      = CELLS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [WORD_BITS-1:0]    cfg_data,
	input  logic                    start,
	output logic                    busy,
	input  logic [COORD_BITS-1:0]   pixel_col,
	input  logic [COORD_BITS-1:0]   pixel_row,
	output logic                    done,
	output logic [COORD_BITS-1:0]   out_col,
	output logic [COORD_BITS-1:0]   out_row,
	output logic [COUNT_BITS-1:0]   iteration_count
);

	word_t                  real_origin_q;
	word_t                  imag_origin_q;
	logic [STEP_BITS-1:0]   real_step_q;
	logic [STEP_BITS-1:0]   imag_step_q;
	logic [LIMIT_BITS-1:0]  limit_q;
	logic [COUNT_BITS-1:0]  limit_eff;

	logic                   busy_q;
	logic                   map_s1;
	logic                   map_s2;
	logic [COORD_BITS-1:0]  col_q;
	logic [COORD_BITS-1:0]  row_q;
	logic signed [WORD_BITS+COORD_BITS:0] pr_s1;
	logic signed [WORD_BITS+COORD_BITS:0] pi_s1;
	word_t                  cr_s2;
	word_t                  ci_s2;

	logic                  v [CELLS+1];
	logic                  lv [CELLS+1];
	word_t                 xs [CELLS+1];
	word_t                 ys [CELLS+1];
	word_t                 crs [CELLS+1];
	word_t                 cis [CELLS+1];
	logic [COUNT_BITS-1:0] cs [CELLS+1];

	logic signed [WORD_BITS+COORD_BITS+1:0] sr;
	logic signed [WORD_BITS+COORD_BITS+1:0] si;
	logic                  fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_origin_q <= RESET_REAL_ORIGIN;
			imag_origin_q <= RESET_IMAG_ORIGIN;
			real_step_q   <= RESET_STEP;
			imag_step_q   <= RESET_STEP;
			limit_q       <= RESET_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_REAL_ORIGIN: real_origin_q <= word_t'(cfg_data);
				REG_IMAG_ORIGIN: imag_origin_q <= word_t'(cfg_data);
				REG_REAL_STEP:   real_step_q   <= cfg_data[STEP_BITS-1:0];
				REG_IMAG_STEP:   imag_step_q   <= cfg_data[STEP_BITS-1:0];
				REG_ITER_LIMIT:  limit_q       <= cfg_data[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (COUNT_BITS >= LIMIT_BITS) begin
			limit_eff = COUNT_BITS'(limit_q);
		end else if ((limit_q >> COUNT_BITS) != '0) begin
			limit_eff = '1;
		end else begin
			limit_eff = COUNT_BITS'(limit_q);
		end
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			map_s1 <= 1'b0;
			map_s2 <= 1'b0;
		end else begin
			map_s1 <= start && !busy_q;
			map_s2 <= map_s1;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The products are taken from the input ports so that they are ready with map_s1.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
		end
		pr_s1 <= $signed({1'b0, pixel_col}) * $signed({1'b0, real_step_q});
		pi_s1 <= $signed({1'b0, pixel_row}) * $signed({1'b0, imag_step_q});
	end

	always_comb begin
		sr = (WORD_BITS+COORD_BITS+2)'(pr_s1) + (WORD_BITS+COORD_BITS+2)'(real_origin_q);
		si = (WORD_BITS+COORD_BITS+2)'(pi_s1) + (WORD_BITS+COORD_BITS+2)'(imag_origin_q);
	end

	always_ff @(posedge clk) begin
		cr_s2 <= (sr > 32'sh7fffffff) ? 32'sh7fffffff :
			(sr < -(WORD_BITS+COORD_BITS+2)'(64'sh80000000)) ? 32'sh80000000 :
			word_t'(sr[WORD_BITS-1:0]);
		ci_s2 <= (si > 32'sh7fffffff) ? 32'sh7fffffff :
			(si < -(WORD_BITS+COORD_BITS+2)'(64'sh80000000)) ? 32'sh80000000 :
			word_t'(si[WORD_BITS-1:0]);
	end

	// The ring closes: the last cell feeds the first unless the point is finished.
	assign fin = v[CELLS] && !lv[CELLS];

	always_comb begin
		if (map_s2) begin
			v[0] = 1'b1; lv[0] = 1'b1; xs[0] = '0; ys[0] = '0;
			crs[0] = cr_s2; cis[0] = ci_s2; cs[0] = '0;
		end else begin
			v[0] = v[CELLS] && lv[CELLS]; lv[0] = lv[CELLS];
			xs[0] = xs[CELLS]; ys[0] = ys[CELLS];
			crs[0] = crs[CELLS]; cis[0] = cis[CELLS]; cs[0] = cs[CELLS];
		end
	end

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		mbe_cell #(.FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_vld(v[g]), .in_live(lv[g]), .in_x(xs[g]), .in_y(ys[g]),
			.in_cr(crs[g]), .in_ci(cis[g]), .in_cnt(cs[g]), .limit(limit_eff),
			.out_vld(v[g+1]), .out_live(lv[g+1]), .out_x(xs[g+1]), .out_y(ys[g+1]),
			.out_cr(crs[g+1]), .out_ci(cis[g+1]), .out_cnt(cs[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			iteration_count <= cs[CELLS];
			out_col         <= col_q;
			out_row         <= row_q;
		end
	end

`ifndef SYNTHESIS
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> (busy_q || $past(done))) else $error("busy dropped without a word");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("word delivered while idle");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("two words in a row");
`endif

endmodule

>>> sv/mbe_cell.sv
`timescale 1ns / 1ps
// One iteration cell: squares in the first stage, test and update in the second.
module mbe_cell
	import mbe_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic                  in_live,
	input  word_t                 in_x,
	input  word_t                 in_y,
	input  word_t                 in_cr,
	input  word_t                 in_ci,
	input  logic [COUNT_BITS-1:0] in_cnt,
	input  logic [COUNT_BITS-1:0] limit,
	output logic                  out_vld,
	output logic                  out_live,
	output word_t                 out_x,
	output word_t                 out_y,
	output word_t                 out_cr,
	output word_t                 out_ci,
	output logic [COUNT_BITS-1:0] out_cnt
);

	localparam int PW = 2 * WORD_BITS;

	logic                  vld_s1;
	logic                  live_s1;
	logic signed [PW-1:0]  xx_s1;
	logic signed [PW-1:0]  yy_s1;
	logic signed [PW-1:0]  xy_s1;
	word_t                 cr_s1;
	word_t                 ci_s1;
	word_t                 x_s1;
	word_t                 y_s1;
	logic [COUNT_BITS-1:0] cnt_s1;

	logic signed [PW-1:0] xx_t;
	logic signed [PW-1:0] yy_t;
	logic signed [PW-1:0] xy_t;
	logic [PW:0]          mag;
	logic [PW:0]          thr;
	logic                 go;
	logic signed [PW+1:0] nx;
	logic signed [PW+1:0] ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		live_s1 <= in_live;
		xx_s1   <= PW'(in_x) * PW'(in_x);
		yy_s1   <= PW'(in_y) * PW'(in_y);
		xy_s1   <= PW'(in_x) * PW'(in_y);
		cr_s1   <= in_cr;
		ci_s1   <= in_ci;
		x_s1    <= in_x;
		y_s1    <= in_y;
		cnt_s1  <= in_cnt;
	end

	always_comb begin
		// Arithmetic right shift floors toward minus infinity.
		xx_t = xx_s1 >>> FRAC_BITS;
		yy_t = yy_s1 >>> FRAC_BITS;
		xy_t = xy_s1 >>> FRAC_BITS;
		mag  = (PW+1)'($unsigned(xx_t)) + (PW+1)'($unsigned(yy_t));
		thr  = (PW+1)'(4) << FRAC_BITS;
		go   = live_s1 && (cnt_s1 < limit) && (mag[PW-1:0] <= thr[PW-1:0]);
		nx   = (PW+2)'(xx_t) - (PW+2)'(yy_t) + (PW+2)'(cr_s1);
		ny   = ((PW+2)'(xy_t) <<< 1) + (PW+2)'(ci_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_live <= go;
		out_cr   <= cr_s1;
		out_ci   <= ci_s1;
		if (go) begin
			out_x   <= (nx > (PW+2)'(32'sh7fffffff)) ? 32'sh7fffffff :
				(nx < -(PW+2)'(64'sh80000000)) ? 32'sh80000000 : word_t'(nx[WORD_BITS-1:0]);
			out_y   <= (ny > (PW+2)'(32'sh7fffffff)) ? 32'sh7fffffff :
				(ny < -(PW+2)'(64'sh80000000)) ? 32'sh80000000 : word_t'(ny[WORD_BITS-1:0]);
			out_cnt <= cnt_s1 + 1'b1;
		end else begin
			out_x   <= x_s1;
			out_y   <= y_s1;
			out_cnt <= cnt_s1;
		end
	end

endmodule
